[rtl/ihc_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 header check package
// Shared constants and types for the IPv4 receive header checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

  localparam logic [3:0] IP_VERSION_FOUR = 4'd4;
  localparam logic [3:0] IHL_MINIMUM     = 4'd5;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] VERDICT_ICMP          = 4'd0;
  localparam logic [3:0] VERDICT_TCP           = 4'd1;
  localparam logic [3:0] VERDICT_UDP           = 4'd2;
  localparam logic [3:0] VERDICT_BAD_VERSION   = 4'd3;
  localparam logic [3:0] VERDICT_SHORT_IHL     = 4'd4;
  localparam logic [3:0] VERDICT_TTL_ZERO      = 4'd5;
  localparam logic [3:0] VERDICT_BAD_CHECKSUM  = 4'd6;
  localparam logic [3:0] VERDICT_NOT_OURS      = 4'd7;
  localparam logic [3:0] VERDICT_UNKNOWN_PROTO = 4'd8;

  localparam logic [5:0] POS_LEN_HI    = 6'd2;
  localparam logic [5:0] POS_LEN_LO    = 6'd3;
  localparam logic [5:0] POS_IDENT_HI  = 6'd4;
  localparam logic [5:0] POS_IDENT_LO  = 6'd5;
  localparam logic [5:0] POS_TTL       = 6'd8;
  localparam logic [5:0] POS_PROTO     = 6'd9;
  localparam logic [5:0] POS_SRC_FIRST = 6'd12;
  localparam logic [5:0] POS_SRC_LAST  = 6'd15;
  localparam logic [5:0] POS_DST_FIRST = 6'd16;
  localparam logic [5:0] POS_DST_LAST  = 6'd19;

  localparam int unsigned RESULT_DATA_W = 112;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic [7:0]  protocol;
  } ihc_result_t;

endpackage

[rtl/ihc_parser.sv]
// ----------------------------------------------------------------------------
// IPv4 header parser
// Holds the per-header parse state, folds each byte into the running
// ones-complement checksum and field captures, and forms the verdict.
// ----------------------------------------------------------------------------
module ihc_parser
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  header_byte,
  input  logic        first_byte,
  input  logic [31:0] local_address,
  output logic        emit,
  output ihc_result_t result
);

  logic        parsing_r,       parsing_nxt;
  logic [5:0]  byte_count_r,    byte_count_nxt;
  logic [5:0]  header_bytes_r,  header_bytes_nxt;
  logic [15:0] sum_r,           sum_nxt;
  logic [7:0]  high_byte_r,     high_byte_nxt;
  logic        ttl_zero_r,      ttl_zero_nxt;
  logic [7:0]  proto_r,         proto_nxt;
  logic [31:0] src_r,           src_nxt;
  logic [31:0] dst_r,           dst_nxt;
  logic [15:0] length_r,        length_nxt;
  logic [15:0] ident_r,         ident_nxt;

  always_comb begin
    logic [16:0] wide_sum;
    logic [6:0]  pos_next;
    logic [3:0]  version;
    logic [3:0]  ihl;

    parsing_nxt      = parsing_r;
    byte_count_nxt   = byte_count_r;
    header_bytes_nxt = header_bytes_r;
    sum_nxt          = sum_r;
    high_byte_nxt    = high_byte_r;
    ttl_zero_nxt     = ttl_zero_r;
    proto_nxt        = proto_r;
    src_nxt          = src_r;
    dst_nxt          = dst_r;
    length_nxt       = length_r;
    ident_nxt        = ident_r;
    emit             = 1'b0;
    result           = '0;
    version          = header_byte[7:4];
    ihl              = header_byte[3:0];
    wide_sum         = {1'b0, sum_r} + {1'b0, high_byte_r, header_byte};
    pos_next         = {1'b0, byte_count_r} + 7'd1;

    if (first_byte) begin
      parsing_nxt      = 1'b0;
      byte_count_nxt   = '0;
      header_bytes_nxt = '0;
      sum_nxt          = '0;
      high_byte_nxt    = '0;
      ttl_zero_nxt     = 1'b0;
      proto_nxt        = '0;
      src_nxt          = '0;
      dst_nxt          = '0;
      length_nxt       = '0;
      ident_nxt        = '0;
      if (version != IP_VERSION_FOUR) begin
        emit           = 1'b1;
        result.verdict = VERDICT_BAD_VERSION;
      end else if (ihl < IHL_MINIMUM) begin
        emit           = 1'b1;
        result.verdict = VERDICT_SHORT_IHL;
      end else begin
        header_bytes_nxt = {ihl, 2'b00};
        high_byte_nxt    = header_byte;
        byte_count_nxt   = 6'd1;
        parsing_nxt      = 1'b1;
      end
    end else if (parsing_r) begin
      if (!byte_count_r[0]) begin
        high_byte_nxt = header_byte;
      end else if (wide_sum[16]) begin
        sum_nxt = wide_sum[15:0] + 16'd1;
      end else begin
        sum_nxt = wide_sum[15:0];
      end

      case (byte_count_r) inside
        POS_LEN_HI, POS_LEN_LO:     length_nxt = {length_r[7:0], header_byte};
        POS_IDENT_HI, POS_IDENT_LO: ident_nxt = {ident_r[7:0], header_byte};
        POS_TTL:                    ttl_zero_nxt = (header_byte == 8'd0);
        POS_PROTO:                  proto_nxt = header_byte;
        [POS_SRC_FIRST:POS_SRC_LAST]: src_nxt = {src_r[23:0], header_byte};
        [POS_DST_FIRST:POS_DST_LAST]: dst_nxt = {dst_r[23:0], header_byte};
        default: ;
      endcase

      if (pos_next < {1'b0, header_bytes_r}) begin
        byte_count_nxt = pos_next[5:0];
      end else begin
        emit                  = 1'b1;
        parsing_nxt           = 1'b0;
        byte_count_nxt        = '0;
        result.source_address = src_nxt;
        result.dest_address   = dst_nxt;
        result.total_length   = length_nxt;
        result.ident          = ident_nxt;
        result.protocol       = proto_nxt;
        if (ttl_zero_nxt) begin
          result.verdict = VERDICT_TTL_ZERO;
        end else if (sum_nxt != 16'hFFFF) begin
          result.verdict = VERDICT_BAD_CHECKSUM;
        end else if (dst_nxt != local_address) begin
          result.verdict = VERDICT_NOT_OURS;
        end else if (proto_nxt == PROTO_ICMP) begin
          result.verdict = VERDICT_ICMP;
        end else if (proto_nxt == PROTO_TCP) begin
          result.verdict = VERDICT_TCP;
        end else if (proto_nxt == PROTO_UDP) begin
          result.verdict = VERDICT_UDP;
        end else begin
          result.verdict = VERDICT_UNKNOWN_PROTO;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parsing_r    <= 1'b0;
      byte_count_r <= '0;
    end else if (step) begin
      parsing_r    <= parsing_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      header_bytes_r <= header_bytes_nxt;
      sum_r          <= sum_nxt;
      high_byte_r    <= high_byte_nxt;
      ttl_zero_r     <= ttl_zero_nxt;
      proto_r        <= proto_nxt;
      src_r          <= src_nxt;
      dst_r          <= dst_nxt;
      length_r       <= length_nxt;
      ident_r        <= ident_nxt;
    end
  end

endmodule

[rtl/ipv4_header_check.sv]
// ----------------------------------------------------------------------------
// IPv4 header check
// Path: a header's last byte (or a rejected first byte) is registered in the
// input stage, then its verdict is registered in the output register.
// Throughput: one header byte per cycle; input stalls only while a verdict
// waits in the output register and the next byte would produce another.
// Reset clears the parser's parsing flag and byte count, the pipeline valids and the local address.
// ----------------------------------------------------------------------------
module ipv4_header_check
  import ihc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [31:0]              cfg_wr_data,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // header_byte
  input  logic                     in_tuser,   // first_byte
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // verdict, source_address, dest_address, total_length, ident, protocol, pad
  output logic [RESULT_DATA_W-1:0] out_tdata
);

  logic                     s1_valid_r;
  logic [7:0]               s1_byte_r;
  logic                     s1_first_r;
  logic [31:0]              local_addr_r;
  logic                     out_valid_r;
  logic [RESULT_DATA_W-1:0] out_data_r;
  logic                     s1_emit;
  logic                     s1_go;
  logic                     out_free;
  ihc_result_t              s1_result;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = !s1_emit || out_free;
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
    end else if (cfg_wr_en) begin
      local_addr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_first_r <= in_tuser;
    end
  end

  ihc_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_valid_r && s1_go),
    .header_byte   (s1_byte_r),
    .first_byte    (s1_first_r),
    .local_address (local_addr_r),
    .emit          (s1_emit),
    .result        (s1_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r && s1_emit) begin
      out_data_r <= {4'd0, s1_result.protocol, s1_result.ident, s1_result.total_length,
                     s1_result.dest_address, s1_result.source_address,
                     s1_result.verdict};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
